/* design/sstf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstf_pkg
// Shared types, constants and the control program of the SSTF scheduler.
// ----------------------------------------------------------------------------
package sstf_pkg;

    // Port widths fixed by the interface.
    localparam int TRACK_W = 16;
    localparam int SEEK_W  = 22;

    // Defaults for the top-level parameters.
    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int TRACK_BITS_DEF  = 16;

    // Input command codes.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    // Program steps; the step counter holds one of these.
    typedef enum logic [2:0] {
        ST_FETCH      = 3'd0,
        ST_SCAN_START = 3'd1,
        ST_SCAN       = 3'd2,
        ST_SERVE      = 3'd3,
        ST_EMIT       = 3'd4,
        ST_CHECK      = 3'd5,
        ST_FINISH     = 3'd6,
        ST_EMIT_OVF   = 3'd7
    } t_step;

    // Datapath operation of one control word.
    typedef enum logic [2:0] {
        OP_FETCH,
        OP_SCAN_START,
        OP_SCAN,
        OP_SERVE,
        OP_EMIT,
        OP_NOP,
        OP_FINISH
    } t_op;

    // Jump condition of one control word.
    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_DISPATCH,
        COND_SCAN_DONE,
        COND_OUT_TAKEN,
        COND_MORE
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_uop;

    // Control store. A condition that is false falls through to the next
    // step, except for waits, which hold the current step.
    function automatic t_uop uop_rom(input t_step s);
        t_uop u;
        unique case (s)
            ST_FETCH:      u = '{OP_FETCH,      COND_DISPATCH,  ST_FETCH};
            ST_SCAN_START: u = '{OP_SCAN_START, COND_ALWAYS,    ST_SCAN};
            ST_SCAN:       u = '{OP_SCAN,       COND_SCAN_DONE, ST_SERVE};
            ST_SERVE:      u = '{OP_SERVE,      COND_ALWAYS,    ST_EMIT};
            ST_EMIT:       u = '{OP_EMIT,       COND_OUT_TAKEN, ST_CHECK};
            ST_CHECK:      u = '{OP_NOP,        COND_MORE,      ST_SCAN_START};
            ST_FINISH:     u = '{OP_FINISH,     COND_ALWAYS,    ST_FETCH};
            ST_EMIT_OVF:   u = '{OP_EMIT,       COND_OUT_TAKEN, ST_FETCH};
        endcase
        return u;
    endfunction

endpackage

/* design/sstf_disk_scheduler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstf_disk_scheduler
// Shortest-seek-time-first request scheduler run by a small microprogram.
// ----------------------------------------------------------------------------
// Usage. The input channel (i_valid / o_ready) carries beats of i_cmd and
// i_track. A load beat appends one request track to the queue. A load into
// a full queue is dropped, and one result beat with o_queue_overflow set and
// all other fields zero is offered in the very next cycle.
// A run beat sets the head track and serves every queued request nearest
// first; ties go to the earliest-loaded request. The output channel
// (o_valid / i_ready) carries one result beat per served request with the
// served track, the distance moved, the running seek total and a last flag.
// A run on an empty queue gives no beat. After a run the queue is empty.
// Steps. Each result comes from a scan-start step, a scan that reads one
// queue entry per cycle from the request memory, then a serve step, the
// output beat and a check step.
// Only one input beat is worked on at a time; o_ready is high only while
// the sequencer sits at its fetch step.
// Stalls. While i_ready is low the sequencer holds at the emit step and the
// result registers keep their value.
// Reset. A synchronous active-low reset empties the queue, clears the served
// marks, zeroes head and seek total and starts the program at fetch.
// ----------------------------------------------------------------------------
module sstf_disk_scheduler #(
    parameter int QUEUE_DEPTH = sstf_pkg::QUEUE_DEPTH_DEF,
    parameter int TRACK_BITS  = sstf_pkg::TRACK_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_cmd,
    input  logic [sstf_pkg::TRACK_W-1:0] i_track,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [sstf_pkg::TRACK_W-1:0] o_served_track,
    output logic [sstf_pkg::TRACK_W-1:0] o_move_distance,
    output logic [sstf_pkg::SEEK_W-1:0]  o_total_seek,
    output logic                         o_last_of_run,
    output logic                         o_queue_overflow
);
    import sstf_pkg::*;

    // Tracks wider than the port are cut to the port width.
    localparam int TRK_W = (TRACK_BITS < TRACK_W) ? TRACK_BITS : TRACK_W;
    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    // Sequencer state.
    t_step r_step, n_step;
    t_uop  uop;

    // Request memory, one write and one registered read port.
    logic [TRK_W-1:0] r_mem [QUEUE_DEPTH];
    logic [TRK_W-1:0] r_rd_data;
    logic [IDX_W-1:0] rd_addr;
    logic             mem_we;

    // Datapath registers.
    logic [QUEUE_DEPTH-1:0] r_marks;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       r_served;
    logic [TRK_W-1:0]       r_head;
    logic [SEEK_W-1:0]      r_seek_sum;
    logic [IDX_W-1:0]       r_scan_idx;
    logic                   r_found;
    logic [IDX_W-1:0]       r_best_idx;
    logic [TRK_W-1:0]       r_best_trk;
    logic [TRK_W-1:0]       r_best_dist;

    logic [TRK_W-1:0]  in_trk;
    logic              in_fire;
    logic              out_fire;
    logic              queue_full;
    logic              scan_last;
    logic              take_entry;
    logic [TRK_W-1:0]  scan_dist;
    logic [SEEK_W-1:0] seek_next;

    assign uop        = uop_rom(r_step);
    assign in_trk     = i_track[TRK_W-1:0];
    assign o_ready    = (uop.op == OP_FETCH);
    assign o_valid    = (uop.op == OP_EMIT);
    assign in_fire    = i_valid && o_ready;
    assign out_fire   = o_valid && i_ready;
    assign queue_full = (r_count >= DEPTH_CNT);
    assign scan_last  = (CNT_W'(r_scan_idx) == (r_count - CNT_W'(1)));
    assign scan_dist  = (r_rd_data >= r_head) ? (r_rd_data - r_head)
                                              : (r_head - r_rd_data);
    // The entry under the scan wins only if it is pending and strictly
    // nearer, so the earliest-loaded entry keeps a tie.
    assign take_entry = !r_marks[r_scan_idx] && (!r_found || scan_dist < r_best_dist);
    assign seek_next  = r_seek_sum + SEEK_W'(r_best_dist);
    assign mem_we     = in_fire && (i_cmd == CMD_LOAD) && !queue_full;

    // Next step from the jump condition of the current control word.
    always_comb begin
        n_step = r_step;
        unique case (uop.cond)
            COND_ALWAYS: begin
                n_step = uop.target;
            end
            COND_DISPATCH: begin
                if (in_fire) begin
                    if (i_cmd == CMD_LOAD) begin
                        n_step = queue_full ? ST_EMIT_OVF : uop.target;
                    end else begin
                        n_step = (r_count == '0) ? uop.target : ST_SCAN_START;
                    end
                end
            end
            COND_SCAN_DONE: begin
                if (scan_last) n_step = uop.target;
            end
            COND_OUT_TAKEN: begin
                if (out_fire) n_step = uop.target;
            end
            COND_MORE: begin
                n_step = (r_served < r_count) ? uop.target : t_step'(r_step + 3'd1);
            end
            default: begin
                n_step = ST_FETCH;
            end
        endcase
    end

    always_comb begin
        rd_addr = '0;
        if (uop.op == OP_SCAN) begin
            rd_addr = r_scan_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_FETCH;
        end else begin
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_count[IDX_W-1:0]] <= in_trk;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Control-side registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marks    <= '0;
            r_count    <= '0;
            r_served   <= '0;
            r_head     <= '0;
            r_seek_sum <= '0;
            r_found    <= 1'b0;
        end else begin
            case (uop.op)
                OP_FETCH: begin
                    if (mem_we) begin
                        r_marks[r_count[IDX_W-1:0]] <= 1'b0;
                        r_count <= r_count + CNT_W'(1);
                    end
                    if (in_fire && i_cmd == CMD_RUN) begin
                        r_head     <= in_trk;
                        r_seek_sum <= '0;
                        r_served   <= '0;
                    end
                end
                OP_SCAN_START: begin
                    r_found <= 1'b0;
                end
                OP_SCAN: begin
                    if (take_entry) r_found <= 1'b1;
                end
                OP_SERVE: begin
                    r_marks[r_best_idx] <= 1'b1;
                    r_head     <= r_best_trk;
                    r_seek_sum <= seek_next;
                    r_served   <= r_served + CNT_W'(1);
                end
                OP_FINISH: begin
                    r_marks <= '0;
                    r_count <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Scan pointer, best candidate and result registers.
    always_ff @(posedge i_clk) begin
        case (uop.op)
            OP_FETCH: begin
                if (in_fire && i_cmd == CMD_LOAD && queue_full) begin
                    o_served_track   <= '0;
                    o_move_distance  <= '0;
                    o_total_seek     <= '0;
                    o_last_of_run    <= 1'b0;
                    o_queue_overflow <= 1'b1;
                end
            end
            OP_SCAN_START: begin
                r_scan_idx <= '0;
            end
            OP_SCAN: begin
                r_scan_idx <= r_scan_idx + IDX_W'(1);
                if (take_entry) begin
                    r_best_idx  <= r_scan_idx;
                    r_best_trk  <= r_rd_data;
                    r_best_dist <= scan_dist;
                end
            end
            OP_SERVE: begin
                o_served_track   <= TRACK_W'(r_best_trk);
                o_move_distance  <= TRACK_W'(r_best_dist);
                o_total_seek     <= seek_next;
                o_last_of_run    <= ((r_served + CNT_W'(1)) == r_count);
                o_queue_overflow <= 1'b0;
            end
            default: begin
            end
        endcase
    end

endmodule
